// ===== hdl/pdc_pkg.sv =====
// Shared types and constants for the pixel difference comparator.
package pdc_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned SUM_W = 10;
	localparam int unsigned CFG_COUNT_W = 3;

	localparam logic [CHAN_W-1:0] DIFF_ALPHA_MARK = 8'd255;
	localparam logic [SUM_W-1:0] SUM_TOLERANCE = 10'd1;

	// channel_count register
	localparam logic [CFG_COUNT_W-1:0] CHANNEL_COUNT_RESET = 3'd4;
	localparam logic [CFG_COUNT_W-1:0] CHANNEL_COUNT_THREE = 3'd3;
	localparam logic REG_CHANNEL_COUNT = 1'b0;

	// one pixel, four channels
	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	// per-pixel outcome of the comparison
	typedef struct packed {
		logic [CHAN_W-1:0] diff_red;
		logic [CHAN_W-1:0] diff_alpha;
		logic              pixel_differs;
	} pix_result_t;

endpackage

// ===== hdl/pixel_diff_compare.sv =====
// Top level of the streaming pixel difference comparator.
//
// Input stream (s_axis): one reference/test pixel pair per item, tlast marks
// the final pixel of an image. Output stream (m_axis): one diff pixel per
// item, with the sticky images_equal flag; tlast copies the input tlast and
// images_equal is final on that item.
// Configuration (APB, register 0 at byte address 0): channel_count, 3 or 4;
// any value other than 3 selects 4-channel mode. Write it only while idle.
// Path from input acceptance to the result on m_axis: an input register, then
// the compare logic into the result register.
// Throughput: one item per cycle; both stages advance together whenever the
// result register is empty or being taken.
// Stall: when m_axis_tready is low the result holds, the input register
// still fills once, then s_axis_tready drops until the output drains.
// Reset (arst_n low): both stages empty, channel_count = 4, images_equal
// flag = 1. After each last pixel the flag returns to 1.
module pixel_diff_compare (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input pixel pairs
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// ref_red, ref_green, ref_blue, ref_alpha, test_red, test_green, test_blue, test_alpha
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,  // last_pixel
	// diff results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// diff_red, diff_alpha, pixel_differs, images_equal, 6 bits zero
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast   // last_result
);
	import pdc_pkg::*;

	logic [CFG_COUNT_W-1:0] channel_count_q;
	logic                   equal_q;
	logic                   cfg_wr;

	pixel_t      ref_pix_s1, test_pix_s1;
	logic        last_s1;
	logic        valid_s1;
	pix_result_t res;
	pix_result_t res_s2;
	logic        equal_s2;
	logic        last_s2;
	logic        valid_s2;
	logic        equal_next;
	logic        adv_s2, adv_s1;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_CHANNEL_COUNT)) begin
			channel_count_q <= pwdata[CFG_COUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CHANNEL_COUNT) ?
	                {{(32-CFG_COUNT_W){1'b0}}, channel_count_q} : '0;

	// pipeline flow control
	assign adv_s2 = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign adv_s1 = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ref_pix_s1.red    <= s_axis_tdata[7:0];
			ref_pix_s1.green  <= s_axis_tdata[15:8];
			ref_pix_s1.blue   <= s_axis_tdata[23:16];
			ref_pix_s1.alpha  <= s_axis_tdata[31:24];
			test_pix_s1.red   <= s_axis_tdata[39:32];
			test_pix_s1.green <= s_axis_tdata[47:40];
			test_pix_s1.blue  <= s_axis_tdata[55:48];
			test_pix_s1.alpha <= s_axis_tdata[63:56];
			last_s1           <= s_axis_tlast;
		end
	end

	// compare logic
	pdc_diff u_diff (
		.ref_pix   (ref_pix_s1),
		.test_pix  (test_pix_s1),
		.four_mode (channel_count_q != CHANNEL_COUNT_THREE),
		.result    (res)
	);

	// sticky equal flag, rearmed after the last pixel of an image
	assign equal_next = equal_q && !res.pixel_differs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			equal_q <= 1'b1;
		end else if (adv_s2) begin
			equal_q <= last_s1 ? 1'b1 : equal_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2   <= res;
			equal_s2 <= equal_next;
			last_s2  <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b0, equal_s2, res_s2.pixel_differs,
	                        res_s2.diff_alpha, res_s2.diff_red};
	assign m_axis_tlast  = last_s2;

endmodule

// ===== hdl/pdc_diff.sv =====
// Per-pixel channel differences, tolerance check and largest difference.
module pdc_diff (
	input  pdc_pkg::pixel_t      ref_pix,
	input  pdc_pkg::pixel_t      test_pix,
	input  logic                 four_mode,
	output pdc_pkg::pix_result_t result
);
	import pdc_pkg::*;

	logic [CHAN_W-1:0] d_red, d_green, d_blue, d_alpha;
	logic [CHAN_W-1:0] max_rg, max_ba, max_all;
	logic [SUM_W-1:0]  sum;
	logic              differs;

	// absolute difference of each channel; alpha drops out in 3-channel mode
	always_comb begin
		d_red   = (ref_pix.red > test_pix.red) ? ref_pix.red - test_pix.red
		                                       : test_pix.red - ref_pix.red;
		d_green = (ref_pix.green > test_pix.green) ? ref_pix.green - test_pix.green
		                                           : test_pix.green - ref_pix.green;
		d_blue  = (ref_pix.blue > test_pix.blue) ? ref_pix.blue - test_pix.blue
		                                         : test_pix.blue - ref_pix.blue;
		if (four_mode) begin
			d_alpha = (ref_pix.alpha > test_pix.alpha) ? ref_pix.alpha - test_pix.alpha
			                                           : test_pix.alpha - ref_pix.alpha;
		end else begin
			d_alpha = '0;
		end
	end

	// sum of differences against the tolerance
	assign sum = SUM_W'(d_red) + SUM_W'(d_green) + SUM_W'(d_blue) + SUM_W'(d_alpha);
	assign differs = (sum > SUM_TOLERANCE);

	// largest channel difference, two-level compare tree
	assign max_rg  = (d_green > d_red) ? d_green : d_red;
	assign max_ba  = (d_alpha > d_blue) ? d_alpha : d_blue;
	assign max_all = (max_ba > max_rg) ? max_ba : max_rg;

	always_comb begin
		result.pixel_differs = differs;
		result.diff_red      = differs ? max_all : '0;
		result.diff_alpha    = (differs && four_mode) ? DIFF_ALPHA_MARK : '0;
	end

endmodule

// ===== dv/pixel_diff_compare_tb.sv =====
`timescale 1ns / 100ps
// Testbench for pixel_diff_compare: directed and random pixel streams checked against a predictor.
module pixel_diff_compare_tb;
	import pdc_pkg::*;

	localparam real CLK_HALF = 6.0;
	localparam int RESET_CYCLES = 11;
	localparam int HOLD_CYCLES = 90;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [2:0] CHAN_COUNT_ADDR = {REG_CHANNEL_COUNT, 2'b00};

	// expected diff pixel, one per input item
	typedef struct {
		logic [CHAN_W-1:0] diff_red;
		logic [CHAN_W-1:0] diff_alpha;
		logic              differs;
		logic              equal;
		logic              last;
	} diff_pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// ref_red, ref_green, ref_blue, ref_alpha, test_red, test_green, test_blue, test_alpha
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0; // last_pixel
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// diff_red, diff_alpha, pixel_differs, images_equal, 6 bits zero
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast; // last_result

	// predictor state
	logic [CFG_COUNT_W-1:0] chan_mode = CHANNEL_COUNT_RESET;
	logic                   equal_track = 1'b1;
	diff_pixel_t            diff_q[$];

	// traffic shaping
	int gap_max = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatch_count = 0;

	pixel_diff_compare DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #(CLK_HALF) clk = ~clk;

	initial begin
		#(2ms);
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic [CHAN_W-1:0] chan_delta(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// diff pixel for one pair; updates the sticky equal flag
	function automatic diff_pixel_t compute_diff(input pixel_t rpix, input pixel_t tpix,
			input logic last);
		diff_pixel_t res;
		logic four;
		logic [CHAN_W-1:0] dr, dg, db, da, mx;
		logic [SUM_W-1:0] sum;
		four = (chan_mode != CHANNEL_COUNT_THREE);
		dr = chan_delta(rpix.red, tpix.red);
		dg = chan_delta(rpix.green, tpix.green);
		db = chan_delta(rpix.blue, tpix.blue);
		da = four ? chan_delta(rpix.alpha, tpix.alpha) : '0;
		sum = SUM_W'(dr) + SUM_W'(dg) + SUM_W'(db) + SUM_W'(da);
		mx = dr;
		if (dg > mx) mx = dg;
		if (db > mx) mx = db;
		if (da > mx) mx = da;
		res.differs = (sum > SUM_TOLERANCE);
		if (res.differs) equal_track = 1'b0;
		res.diff_red = res.differs ? mx : '0;
		res.diff_alpha = (res.differs && four) ? DIFF_ALPHA_MARK : '0;
		res.equal = equal_track;
		res.last = last;
		if (last) equal_track = 1'b1;
		return res;
	endfunction

	// send one pixel pair, then idle if gaps are enabled and the current burst is over
	task automatic send_pair(input pixel_t rpix, input pixel_t tpix, input logic last);
		int gap;
		diff_pixel_t exp_pix;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tpix, rpix};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		exp_pix = compute_diff(rpix, tpix, last);
		diff_q = {diff_q, exp_pix};
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				gap = $urandom_range(gap_max, 1);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
	endtask

	// wait until every pending result came back, then let the pipeline settle
	task automatic drain();
		while (diff_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == CHAN_COUNT_ADDR) chan_mode = data[CFG_COUNT_W-1:0];
	endtask

	task automatic apb_read_check(input logic [2:0] addr);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_COUNT_W-1:0] !== chan_mode)
			report_mismatch("channel_count readback", 32'(prdata[CFG_COUNT_W-1:0]),
				32'(chan_mode));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_channels(input logic [31:0] value);
		apb_write(CHAN_COUNT_ADDR, value);
		// leave the bus idle between the two transfers
		@(posedge clk);
		apb_read_check(CHAN_COUNT_ADDR);
	endtask

	function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.alpha = a;
		return p;
	endfunction

	// test pixel close to the reference: equal, off by one, or random per channel
	function automatic pixel_t near_pixel(input pixel_t base);
		pixel_t p;
		logic [7:0] c;
		p = base;
		if ($urandom_range(99) < 30) return p;
		for (int i = 0; i < 4; i++) begin
			c = base[i*8 +: 8];
			case ($urandom_range(3))
				0: p[i*8 +: 8] = c;
				1: p[i*8 +: 8] = c + 8'd1;
				2: p[i*8 +: 8] = c - 8'd1;
				default: p[i*8 +: 8] = 8'($urandom);
			endcase
		end
		return p;
	endfunction

	// result checker
	always @(posedge clk) begin
		diff_pixel_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (diff_q.size() == 0) begin
				report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
			end else begin
				want = diff_q.pop_front();
				if (m_axis_tdata[7:0] !== want.diff_red)
					report_mismatch("diff_red", 32'(m_axis_tdata[7:0]), 32'(want.diff_red));
				if (m_axis_tdata[15:8] !== want.diff_alpha)
					report_mismatch("diff_alpha", 32'(m_axis_tdata[15:8]),
						32'(want.diff_alpha));
				if (m_axis_tdata[16] !== want.differs)
					report_mismatch("pixel_differs", 32'(m_axis_tdata[16]),
						32'(want.differs));
				if (m_axis_tdata[17] !== want.equal)
					report_mismatch("images_equal", 32'(m_axis_tdata[17]), 32'(want.equal));
				if (m_axis_tlast !== want.last)
					report_mismatch("last_result", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// extremes, tolerance of one and image boundaries in 4-channel mode
	task automatic test_four_channel();
		gap_max = 2;
		stall_pct = 30;
		set_channels(CHANNEL_COUNT_RESET);
		send_pair(make_pixel(0, 0, 0, 0), make_pixel(0, 0, 0, 0), 1'b0);
		send_pair(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF), make_pixel(0, 0, 0, 0), 1'b0);
		send_pair(make_pixel(10, 20, 30, 40), make_pixel(10, 21, 30, 40), 1'b0);
		send_pair(make_pixel(10, 20, 30, 40), make_pixel(11, 19, 30, 40), 1'b0);
		send_pair(make_pixel(0, 0, 0, 8'hFF), make_pixel(0, 0, 0, 0), 1'b1);
		send_pair(make_pixel(5, 5, 5, 5), make_pixel(5, 5, 5, 6), 1'b1);
		send_pair(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55), make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA),
			1'b1);
		stop_sending();
		drain();
	endtask

	// alpha ignored in 3-channel mode; upper write bits dropped
	task automatic test_three_channel();
		set_channels(32'hFFFF_FFFB);
		send_pair(make_pixel(1, 2, 3, 0), make_pixel(1, 2, 3, 8'hFF), 1'b0);
		send_pair(make_pixel(8'hFF, 0, 0, 9), make_pixel(0, 0, 0, 200), 1'b0);
		send_pair(make_pixel(7, 7, 7, 7), make_pixel(7, 8, 7, 0), 1'b1);
		send_pair(make_pixel(0, 8'hFF, 0, 0), make_pixel(0, 8'hFD, 0, 0), 1'b1);
		stop_sending();
		drain();
	endtask

	// every unsupported count acts as 4-channel mode
	task automatic test_odd_counts();
		logic [CFG_COUNT_W-1:0] odd_counts[6] = '{0, 1, 2, 5, 6, 7};
		foreach (odd_counts[i]) begin
			set_channels(32'(odd_counts[i]));
			send_pair(make_pixel(3, 3, 3, 0), make_pixel(3, 3, 3, 8'h80), 1'b1);
			stop_sending();
			drain();
		end
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		pixel_t rpix;
		gap_max = 0;
		stall_pct = 0;
		set_channels(CHANNEL_COUNT_RESET);
		hold_requests++;
		for (int i = 0; i < 30; i++) begin
			rpix = pixel_t'($urandom);
			send_pair(rpix, near_pixel(rpix), (i % 10) == 9);
		end
		stop_sending();
		drain();
	endtask

	// random images of random length under one setting
	task automatic test_random_images(input logic [31:0] count, input int items,
			input int gaps, input int stall);
		pixel_t rpix;
		int sent;
		int img_len;
		gap_max = gaps;
		stall_pct = stall;
		set_channels(count);
		sent = 0;
		while (sent < items) begin
			img_len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
			for (int i = 0; i < img_len; i++) begin
				rpix = pixel_t'($urandom);
				send_pair(rpix, near_pixel(rpix), i == img_len - 1);
			end
			sent += img_len;
		end
		stop_sending();
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_four_channel();
		test_three_channel();
		test_odd_counts();
		test_backpressure();
		test_random_images(32'd4, 80, 6, 30);
		test_random_images(32'd3, 80, 0, 0);
		test_random_images(32'd7, 80, 3, 60);
		test_random_images(32'd3, 80, 8, 20);
		test_random_images(32'd0, 80, 2, 50);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pdc_pkg.sv
hdl/pdc_diff.sv
hdl/pixel_diff_compare.sv
dv/pixel_diff_compare_tb.sv
